[hdl/swm_pkg.sv]
// Shared types and constants for the sliding-window median filter.
`default_nettype none

package swm_pkg;

	// Sequencer phases of one request.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_SELECT
	} state_t;

	// Operation broadcast to every sorting cell.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_REMOVE,
		OP_INSERT
	} cell_op_t;

	// Lower median sits at sorted position (k+1)/MEDIAN_DIV, counting from 1.
	localparam int MEDIAN_DIV = 2;

endpackage

`default_nettype wire

[hdl/sliding_window_median.sv]
// Top level of the sliding-window median filter: sequencer, cell row, output register.
`default_nettype none

// Sliding-window median filter over signed samples. A row of WINDOW_MAX
// sorting cells keeps the window in ascending order; each cell also keeps
// the age of its entry, so the oldest sample is found by age and no
// separate delay line is needed. While the window is filling, a request
// steps through insert, select and back to idle; once it is full, through
// remove, insert, select and idle. The sequencer moves the whole cell row
// through one phase per cycle, except while it holds in select. Until
// window_size samples have arrived in a sequence no median comes out; after
// that every sample gives one median, the lower one, at sorted position
// (window_size+1)/2. window_size 0 acts as 1, values above WINDOW_MAX
// saturate. A write of window_size, or a sample with starts_sequence set,
// starts a new sequence. Write window_size only while the block is idle.
// The median sits in an output register, so a finished result may wait
// for out_ready while the next request is already accepted; if that next
// request also gives a median before the first has left, the sequencer
// holds in its select phase until the output register frees up.

module sliding_window_median
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    window_size_we,
	input  wire logic [6:0]              window_size,
	// sample request
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                    starts_sequence,
	// median result
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0]      median
);

	// count needs to reach WINDOW_MAX, ages and indexes stay below it
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	state_t                  state_q, state_d;
	cell_op_t                cell_op;
	logic [6:0]              window_size_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           k;
	logic [CW-1:0]           mid;
	logic [AW-1:0]           oldest_age;
	logic [CW-1:0]           start_fill;
	logic [SAMPLE_WIDTH-1:0] sample_q;
	logic [SAMPLE_WIDTH-1:0] median_q;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] mid_value;
	logic                    accept;
	logic                    select_stall;
	logic                    result_done;

	// cell row wiring
	logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
	logic [AW-1:0]           cell_age   [WINDOW_MAX];
	logic [WINDOW_MAX:0]     gt_chain;
	logic [WINDOW_MAX:0]     del_chain;

	// Effective window: zero acts as one, saturate at WINDOW_MAX.
	always_comb begin
		int unsigned ws;
		int unsigned kk;
		ws = 32'(window_size_q);
		if (ws == 0)
			kk = 1;
		else if (ws > WINDOW_MAX)
			kk = WINDOW_MAX;
		else
			kk = ws;
		k = CW'(kk);
	end

	assign oldest_age = AW'(k - CW'(1));
	// zero-based slot of the lower median: (k+1)/2 - 1
	assign mid        = CW'((k + CW'(1)) / MEDIAN_DIV) - CW'(1);

	// Fill count the new sample sees: cleared by start flag or a stale count.
	always_comb begin
		start_fill = fill_q;
		if (starts_sequence)
			start_fill = '0;
		if (start_fill > k)
			start_fill = '0;
	end

	assign accept = in_valid && in_ready;

	// A new median has to wait in select while the previous one still sits
	// in the output register and is not taken this cycle.
	assign select_stall = (fill_q == k) && out_valid_q && !out_ready;
	assign result_done  = (state_q == ST_SELECT) && (fill_q == k) && !select_stall;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (start_fill == k)
						state_d = ST_REMOVE;
					else
						state_d = ST_INSERT;
				end
			end
			ST_REMOVE: state_d = ST_INSERT;
			ST_INSERT: state_d = ST_SELECT;
			ST_SELECT: state_d = select_stall ? ST_SELECT : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		cell_op  = OP_HOLD;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_REMOVE: cell_op  = OP_REMOVE;
			ST_INSERT: cell_op  = OP_INSERT;
			ST_SELECT: cell_op  = OP_HOLD;
			default:   cell_op  = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= 7'd1;
			fill_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new median may land in the same cycle the old one leaves
			if (result_done)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (window_size_we) begin
				window_size_q <= window_size;
				fill_q        <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept)
							fill_q <= start_fill;
					end
					ST_REMOVE: fill_q <= fill_q - CW'(1);
					ST_INSERT: fill_q <= fill_q + CW'(1);
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= sample;
		if (result_done)
			median_q <= mid_value;
	end

	// Pick the median cell: one-hot on index, OR-combined.
	always_comb begin
		mid_value = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (CW'(i) == mid)
				mid_value = mid_value | cell_value[i];
		end
	end

	assign gt_chain[0]  = 1'b0;
	assign del_chain[0] = 1'b0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [SAMPLE_WIDTH-1:0] left_value;
		logic [AW-1:0]           left_age;
		logic [SAMPLE_WIDTH-1:0] right_value;
		logic [AW-1:0]           right_age;

		if (i == 0) begin : g_first
			assign left_value = sample_q;
			assign left_age   = '0;
		end else begin : g_inner_l
			assign left_value = cell_value[i-1];
			assign left_age   = cell_age[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_last
			assign right_value = sample_q;
			assign right_age   = '0;
		end else begin : g_inner_r
			assign right_value = cell_value[i+1];
			assign right_age   = cell_age[i+1];
		end

		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.AGE_WIDTH    (AW),
			.CNT_WIDTH    (CW),
			.IDX          (i)
		) u_cell (
			.clk         (clk),
			.op          (cell_op),
			.sample      (sample_q),
			.count       (fill_q),
			.oldest_age  (oldest_age),
			.left_value  (left_value),
			.left_age    (left_age),
			.left_gt     (gt_chain[i]),
			.right_value (right_value),
			.right_age   (right_age),
			.del_in      (del_chain[i]),
			.gt_out      (gt_chain[i+1]),
			.del_out     (del_chain[i+1]),
			.value       (cell_value[i]),
			.age         (cell_age[i])
		);
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

endmodule

`default_nettype wire

[hdl/swm_cell.sv]
// One sorting cell: holds one sorted window entry and its age.
`default_nettype none

module swm_cell
	import swm_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32,
	parameter int AGE_WIDTH    = 6,
	parameter int CNT_WIDTH    = 7,
	parameter int IDX          = 0
) (
	input  wire logic                    clk,
	input  wire cell_op_t                op,
	input  wire logic [SAMPLE_WIDTH-1:0] sample,
	input  wire logic [CNT_WIDTH-1:0]    count,
	input  wire logic [AGE_WIDTH-1:0]    oldest_age,
	input  wire logic [SAMPLE_WIDTH-1:0] left_value,
	input  wire logic [AGE_WIDTH-1:0]    left_age,
	input  wire logic                    left_gt,
	input  wire logic [SAMPLE_WIDTH-1:0] right_value,
	input  wire logic [AGE_WIDTH-1:0]    right_age,
	input  wire logic                    del_in,
	output logic                         gt_out,
	output logic                         del_out,
	output logic [SAMPLE_WIDTH-1:0]      value,
	output logic [AGE_WIDTH-1:0]         age
);

	logic [SAMPLE_WIDTH-1:0] value_q;
	logic [AGE_WIDTH-1:0]    age_q;
	logic                    valid;
	logic                    match;

	assign valid   = CNT_WIDTH'(IDX) < count;
	// empty cells act as +infinity so the insert point lands after the data
	assign gt_out  = !valid || ($signed(value_q) > $signed(sample));
	assign match   = valid && (age_q == oldest_age);
	// at or past the removed entry: pull from the right
	assign del_out = del_in | match;

	assign value = value_q;
	assign age   = age_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_REMOVE: begin
				if (del_out) begin
					value_q <= right_value;
					age_q   <= right_age;
				end
			end
			OP_INSERT: begin
				if (gt_out) begin
					if (left_gt) begin
						value_q <= left_value;
						age_q   <= left_age + AGE_WIDTH'(1);
					end else begin
						value_q <= sample;
						age_q   <= '0;
					end
				end else begin
					age_q <= age_q + AGE_WIDTH'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
